FILE: rtl/uhe_pkg.sv
`default_nettype none
package uhe_pkg;

  // codec mode register values
  typedef logic [1:0] mode_t;
  localparam mode_t MODE_URL_ENC  = 2'd0;
  localparam mode_t MODE_URL_DEC  = 2'd1;
  localparam mode_t MODE_HTML_ENC = 2'd2;

  // decoder hold state
  typedef logic [1:0] pend_t;
  localparam pend_t PEND_NONE  = 2'd0;
  localparam pend_t PEND_PCT   = 2'd1;
  localparam pend_t PEND_DIGIT = 2'd2;

  // most bytes one request can expand into
  localparam int MaxBytes = 6;
  localparam int CountW   = $clog2(MaxBytes + 1);
  localparam int IdxW     = $clog2(MaxBytes);

  // character codes
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_QUOT  = 8'h22;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_TILDE = 8'h7E;

  // one classified request, bytes in output order
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CountW-1:0]        count;
    logic                     last;
  } job_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_hex(input logic [7:0] b);
    return is_digit(b) || ((b >= 8'h41) && (b <= 8'h46)) ||
           ((b >= 8'h61) && (b <= 8'h66));
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] b);
    logic [7:0] v;
    if (is_digit(b)) begin
      v = b - 8'h30;
    end else if ((b >= 8'h41) && (b <= 8'h46)) begin
      v = b - 8'h37;
    end else if ((b >= 8'h61) && (b <= 8'h66)) begin
      v = b - 8'h57;
    end else begin
      v = 8'h00;
    end
    return v[3:0];
  endfunction

  function automatic logic is_plain(input logic [7:0] b);
    return is_digit(b) || ((b >= 8'h41) && (b <= 8'h5A)) ||
           ((b >= 8'h61) && (b <= 8'h7A)) || (b == CH_DASH) ||
           (b == CH_DOT) || (b == CH_UNDER) || (b == CH_TILDE);
  endfunction

  // uppercase hex character for a nibble
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return 8'h30 + {4'h0, nib};
    end else begin
      return 8'h37 + {4'h0, nib};
    end
  endfunction

endpackage
`default_nettype wire

FILE: rtl/url_html_escape_codec.sv
// a request goes through a queue slot, the current-request register and the
//   single output byte register; one output byte per cycle while out_ready
//   allows, and a request holds the output side until its last byte is out
// input takes one byte per cycle while the two-entry request queue has room
// reset: mode returns to url encode, held escape bytes, queue and output clear
`default_nettype none
module url_html_escape_codec (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  input  wire logic        string_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             run_last,
  output logic             string_done
);
  import uhe_pkg::*;

  mode_t codec_mode;
  logic  mode_write;
  logic  q_full;
  logic  push;
  job_t  push_job;
  logic  pop;
  logic  q_valid;
  job_t  q_job;

  // register port
  assign pready     = 1'b1;
  assign mode_write = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata     = (paddr[2] == 1'b0) ? {30'h0, codec_mode} : 32'h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      codec_mode <= MODE_URL_ENC;
    end else if (mode_write) begin
      codec_mode <= pwdata[1:0];
    end
  end

  uhe_front u_front (
    .clk         (clk),
    .rst         (rst),
    .mode        (codec_mode),
    .mode_write  (mode_write),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_byte     (in_byte),
    .string_last (string_last),
    .q_full      (q_full),
    .push        (push),
    .push_job    (push_job)
  );

  uhe_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_job    (q_job)
  );

  uhe_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_job       (q_job),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .run_last    (run_last),
    .string_done (string_done)
  );

endmodule
`default_nettype wire

FILE: rtl/uhe_front.sv
`default_nettype none
module uhe_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire uhe_pkg::mode_t mode,
  input  wire logic           mode_write,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [7:0]     in_byte,
  input  wire logic           string_last,
  input  wire logic           q_full,
  output logic                push,
  output uhe_pkg::job_t       push_job
);
  import uhe_pkg::*;

  pend_t            pending_count, pending_count_next;
  logic [7:0]       pending_digit, pending_digit_next;
  logic [MaxBytes-1:0][7:0] bytes;
  logic [CountW-1:0] n;
  logic             do_fresh;
  logic             accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // classify the byte and build its expansion
  always_comb begin
    bytes              = '0;
    n                  = '0;
    do_fresh           = 1'b0;
    pending_count_next = pending_count;
    pending_digit_next = pending_digit;
    unique case (mode)
      MODE_URL_ENC: begin
        if (is_plain(in_byte)) begin
          bytes[0] = in_byte;
          n        = CountW'(1);
        end else begin
          bytes[0] = CH_PCT;
          bytes[1] = hex_char(in_byte[7:4]);
          bytes[2] = hex_char(in_byte[3:0]);
          n        = CountW'(3);
        end
      end
      MODE_URL_DEC: begin
        // escape in progress
        unique case (pending_count)
          PEND_PCT: begin
            if (is_hex(in_byte)) begin
              pending_count_next = PEND_DIGIT;
              pending_digit_next = in_byte;
            end else begin
              bytes[n[IdxW-1:0]] = CH_PCT;
              n                  = n + CountW'(1);
              pending_count_next = PEND_NONE;
              do_fresh           = 1'b1;
            end
          end
          PEND_DIGIT: begin
            pending_count_next = PEND_NONE;
            if (is_hex(in_byte)) begin
              bytes[n[IdxW-1:0]] = {hex_value(pending_digit), hex_value(in_byte)};
              n                  = n + CountW'(1);
            end else begin
              bytes[n[IdxW-1:0]] = CH_PCT;
              n                  = n + CountW'(1);
              bytes[n[IdxW-1:0]] = pending_digit;
              n                  = n + CountW'(1);
              do_fresh           = 1'b1;
            end
          end
          default: begin
            pending_count_next = PEND_NONE;
            do_fresh           = 1'b1;
          end
        endcase
        // byte seen with nothing held
        if (do_fresh) begin
          if (in_byte == CH_PCT) begin
            pending_count_next = PEND_PCT;
          end else begin
            bytes[n[IdxW-1:0]] = (in_byte == CH_PLUS) ? CH_SPACE : in_byte;
            n                  = n + CountW'(1);
          end
        end
        // flush held bytes at end of string
        if (string_last) begin
          if (pending_count_next == PEND_PCT) begin
            bytes[n[IdxW-1:0]] = CH_PCT;
            n                  = n + CountW'(1);
          end else if (pending_count_next == PEND_DIGIT) begin
            bytes[n[IdxW-1:0]] = CH_PCT;
            n                  = n + CountW'(1);
            bytes[n[IdxW-1:0]] = pending_digit_next;
            n                  = n + CountW'(1);
          end
          pending_count_next = PEND_NONE;
          pending_digit_next = '0;
        end
      end
      MODE_HTML_ENC: begin
        unique case (in_byte)
          CH_LT: begin
            bytes[0] = CH_AMP;
            bytes[1] = 8'h6C;
            bytes[2] = 8'h74;
            bytes[3] = CH_SEMI;
            n        = CountW'(4);
          end
          CH_GT: begin
            bytes[0] = CH_AMP;
            bytes[1] = 8'h67;
            bytes[2] = 8'h74;
            bytes[3] = CH_SEMI;
            n        = CountW'(4);
          end
          CH_AMP: begin
            bytes[0] = CH_AMP;
            bytes[1] = 8'h61;
            bytes[2] = 8'h6D;
            bytes[3] = 8'h70;
            bytes[4] = CH_SEMI;
            n        = CountW'(5);
          end
          CH_QUOT: begin
            bytes[0] = CH_AMP;
            bytes[1] = 8'h71;
            bytes[2] = 8'h75;
            bytes[3] = 8'h6F;
            bytes[4] = 8'h74;
            bytes[5] = CH_SEMI;
            n        = CountW'(6);
          end
          CH_APOS: begin
            bytes[0] = CH_AMP;
            bytes[1] = CH_HASH;
            bytes[2] = 8'h33;
            bytes[3] = 8'h39;
            bytes[4] = CH_SEMI;
            n        = CountW'(5);
          end
          default: begin
            bytes[0] = in_byte;
            n        = CountW'(1);
          end
        endcase
      end
      default: begin
        bytes[0] = in_byte;
        n        = CountW'(1);
      end
    endcase
  end

  // requests with no output bytes never enter the queue
  assign push           = accept && (n != '0);
  assign push_job.bytes = bytes;
  assign push_job.count = n;
  assign push_job.last  = string_last;

  // decoder hold state
  always_ff @(posedge clk) begin
    if (rst || mode_write) begin
      pending_count <= PEND_NONE;
      pending_digit <= '0;
    end else if (accept) begin
      pending_count <= pending_count_next;
      pending_digit <= pending_digit_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/uhe_queue.sv
`default_nettype none
module uhe_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire uhe_pkg::job_t push_job,
  output logic               full,
  input  wire logic          pop,
  output logic               q_valid,
  output uhe_pkg::job_t      q_job
);
  import uhe_pkg::*;

  localparam int Depth = 2;
  localparam int PtrW  = $clog2(Depth);

  job_t             slots [Depth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [PtrW:0]    fill;

  assign full    = (fill == (PtrW+1)'(Depth));
  assign q_valid = (fill != '0);
  assign q_job   = slots[rd_ptr];

  // slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        fill <= fill + (PtrW+1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (PtrW+1)'(1);
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/uhe_back.sv
`default_nettype none
module uhe_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_valid,
  input  wire uhe_pkg::job_t q_job,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [7:0]         out_byte,
  output logic               run_last,
  output logic               string_done
);
  import uhe_pkg::*;

  job_t            job;
  logic            job_valid;
  logic [IdxW-1:0] idx;
  logic            take;
  logic            emit;
  logic            fin;

  assign take = !out_valid || out_ready;
  assign emit = job_valid && take;
  assign fin  = (CountW'(idx) == (job.count - CountW'(1)));
  assign pop  = q_valid && (!job_valid || (emit && fin));

  // current request and byte index
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      idx       <= '0;
    end else if (pop) begin
      job_valid <= 1'b1;
      idx       <= '0;
    end else if (emit && fin) begin
      job_valid <= 1'b0;
    end else if (emit) begin
      idx <= idx + IdxW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= q_job;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte    <= job.bytes[idx];
      run_last    <= fin;
      string_done <= fin && job.last;
    end
  end

endmodule
`default_nettype wire

FILE: sim/tb.sv
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import uhe_pkg::*;

  // unused mode value, bytes pass through unchanged
  localparam mode_t MODE_PASS = 2'd3;
  localparam logic [2:0] REG_MODE_ADDR = 3'd0;
  localparam int MAX_REPORTS = 10;
  localparam int SETTLE_CYCLES = 12;
  localparam int LONG_HOLD = 80;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic [7:0] data;
    logic       run_end;
    logic       str_end;
  } out_rec_t;

  // expected output bytes of the codec, worked out per accepted request
  class escape_checker;
    mode_t      mode;
    pend_t      held;
    logic [7:0] held_digit;
    logic [7:0] emitted[$];
    out_rec_t   expected_out[$];
    int         fail_count;

    function new();
      mode = MODE_URL_ENC;
      held = PEND_NONE;
      held_digit = 8'h00;
      fail_count = 0;
    endfunction

    // a mode write drops any half-collected escape
    function void set_mode(mode_t m);
      mode = m;
      held = PEND_NONE;
      held_digit = 8'h00;
    endfunction

    function void flag(string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS) $display("mismatch: %s", msg);
    endfunction

    function bit hex_ok(logic [7:0] b);
      return (b >= "0" && b <= "9") || (b >= "A" && b <= "F") || (b >= "a" && b <= "f");
    endfunction

    function logic [3:0] nibble(logic [7:0] b);
      logic [7:0] v;
      if (b >= "0" && b <= "9") v = b - "0";
      else if (b >= "A" && b <= "F") v = b - "A" + 8'd10;
      else if (b >= "a" && b <= "f") v = b - "a" + 8'd10;
      else v = 8'h00;
      return v[3:0];
    endfunction

    function bit url_safe(logic [7:0] b);
      return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") ||
             b == "-" || b == "." || b == "_" || b == "~";
    endfunction

    function logic [7:0] upper_hex(logic [3:0] n);
      return (n < 4'd10) ? (8'h30 + n) : (8'h41 + n - 4'd10);
    endfunction

    function void append_byte(logic [7:0] b);
      emitted.insert(emitted.size(), b);
    endfunction

    function void emit_text(string s);
      for (int i = 0; i < s.len(); i++) append_byte(s[i]);
    endfunction

    // decode with nothing held
    function void decode_fresh(logic [7:0] b);
      if (b == CH_PCT) held = PEND_PCT;
      else if (b == CH_PLUS) append_byte(CH_SPACE);
      else append_byte(b);
    endfunction

    function void decode_byte(logic [7:0] b, logic last);
      case (held)
        PEND_PCT: begin
          if (hex_ok(b)) begin
            held = PEND_DIGIT;
            held_digit = b;
          end else begin
            append_byte(CH_PCT);
            held = PEND_NONE;
            decode_fresh(b);
          end
        end
        PEND_DIGIT: begin
          if (hex_ok(b)) begin
            append_byte({nibble(held_digit), nibble(b)});
            held = PEND_NONE;
          end else begin
            append_byte(CH_PCT);
            append_byte(held_digit);
            held = PEND_NONE;
            decode_fresh(b);
          end
        end
        default: begin
          held = PEND_NONE;
          decode_fresh(b);
        end
      endcase
      // end of string flushes whatever is held
      if (last) begin
        if (held == PEND_PCT) begin
          append_byte(CH_PCT);
        end else if (held == PEND_DIGIT) begin
          append_byte(CH_PCT);
          append_byte(held_digit);
        end
        held = PEND_NONE;
        held_digit = 8'h00;
      end
    endfunction

    function void note_request(logic [7:0] b, logic last);
      out_rec_t rec;
      emitted.delete();
      case (mode)
        MODE_URL_ENC: begin
          if (url_safe(b)) begin
            append_byte(b);
          end else begin
            append_byte(CH_PCT);
            append_byte(upper_hex(b[7:4]));
            append_byte(upper_hex(b[3:0]));
          end
        end
        MODE_URL_DEC: decode_byte(b, last);
        MODE_HTML_ENC: begin
          case (b)
            CH_LT:   emit_text("&lt;");
            CH_GT:   emit_text("&gt;");
            CH_AMP:  emit_text("&amp;");
            CH_QUOT: emit_text("&quot;");
            CH_APOS: emit_text("&#39;");
            default: append_byte(b);
          endcase
        end
        default: append_byte(b);
      endcase
      foreach (emitted[k]) begin
        rec.data = emitted[k];
        rec.run_end = (k == emitted.size() - 1);
        rec.str_end = rec.run_end && last;
        expected_out.insert(expected_out.size(), rec);
      end
    endfunction

    function void check_result(logic [7:0] b, logic rl, logic sd);
      out_rec_t e;
      if (expected_out.size() == 0) begin
        flag($sformatf("unexpected byte %02h run_last %0b string_done %0b", b, rl, sd));
      end else begin
        e = expected_out.pop_front();
        if (e.data !== b || e.run_end !== rl || e.str_end !== sd)
          flag($sformatf({"byte exp %02h got %02h, run_last exp %0b got %0b, ",
                          "string_done exp %0b got %0b"},
                         e.data, b, e.run_end, rl, e.str_end, sd));
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid, in_ready;
  logic [7:0]  in_byte;
  logic        string_last;
  logic        out_valid, out_ready;
  logic [7:0]  out_byte;
  logic        run_last, string_done;

  escape_checker sb;
  int burst_left;
  int req_count;
  bit hold_done;

  url_html_escape_codec dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte), .string_last(string_last),
    .out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
    .run_last(run_last), .string_done(string_done)
  );

  always #4 clk = ~clk;

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_byte, run_last, string_done);
  end

  // run limit
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAIL url_html_escape_codec");
    $finish;
  end

  // receiver stall pattern, with one long hold-off once traffic is flowing
  initial begin
    int seg_len;
    int style;
    out_ready <= 1'b0;
    hold_done = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      seg_len = $urandom_range(8, 48);
      style = $urandom_range(0, 3);
      for (int i = 0; i < seg_len; i++) begin
        if (!hold_done && req_count >= 90) begin
          out_ready <= 1'b0;
          repeat (LONG_HOLD) @(negedge clk);
          hold_done = 1'b1;
        end
        case (style)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= (i % 3 != 0);
        endcase
        @(negedge clk);
      end
    end
  end

  // offer one request, then maybe close the burst with a gap
  task automatic offer(input logic [7:0] b, input logic last);
    in_valid <= 1'b1;
    in_byte <= b;
    string_last <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(b, last);
    req_count++;
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 50) : $urandom_range(1, 10);
    end
  endtask

  // stop sending and wait out every expected byte plus pipeline slack
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.expected_out.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // apb write of the mode register, then read it back
  task automatic set_codec_mode(input mode_t m);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_MODE_ADDR;
    pwdata <= {30'd0, m};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.set_mode(m);
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[1:0] !== m) sb.flag($sformatf("mode readback exp %0d got %0d", m, prdata[1:0]));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [7:0] rand_hex();
    case ($urandom_range(0, 2))
      0: return 8'h30 + 8'($urandom_range(0, 9));
      1: return 8'h41 + 8'($urandom_range(0, 5));
      default: return 8'h61 + 8'($urandom_range(0, 5));
    endcase
  endfunction

  function automatic logic [7:0] rand_non_hex();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while ((b >= "0" && b <= "9") || (b >= "A" && b <= "F") || (b >= "a" && b <= "f"));
    return b;
  endfunction

  function automatic logic [7:0] pick_special();
    case ($urandom_range(0, 9))
      0: return CH_LT;
      1: return CH_GT;
      2: return CH_AMP;
      3: return CH_QUOT;
      4: return CH_APOS;
      5: return CH_PCT;
      6: return CH_PLUS;
      7: return CH_TILDE;
      8: return CH_SPACE;
      default: return CH_UNDER;
    endcase
  endfunction

  // decode traffic: mostly well-formed escapes, some broken ones and noise
  task automatic run_decode(input int n);
    logic [7:0] seq[$];
    int kind;
    while (seq.size() < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        seq = {seq, CH_PCT, rand_hex(), rand_hex()};
      end else if (kind < 60) begin
        seq = {seq, 8'h61 + 8'($urandom_range(0, 25))};
      end else if (kind < 68) begin
        seq = {seq, CH_PLUS};
      end else if (kind < 76) begin
        seq = {seq, CH_PCT, rand_non_hex()};
      end else if (kind < 84) begin
        seq = {seq, CH_PCT, rand_hex(), rand_non_hex()};
      end else if (kind < 94) begin
        seq = {seq, 8'($urandom_range(0, 255))};
      end else begin
        seq = {seq, CH_PCT};
      end
    end
    foreach (seq[i]) offer(seq[i], $urandom_range(0, 7) == 0);
  endtask

  // encode traffic: random bytes, biased toward escaped characters
  task automatic run_encode(input int n);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      b = ($urandom_range(0, 9) < 3) ? pick_special() : 8'($urandom_range(0, 255));
      offer(b, $urandom_range(0, 5) == 0);
    end
  endtask

  initial begin
    mode_t phase_modes[8];
    phase_modes = '{MODE_URL_DEC, MODE_URL_ENC, MODE_HTML_ENC, MODE_URL_DEC,
                    MODE_URL_ENC, MODE_URL_DEC, MODE_HTML_ENC, MODE_URL_DEC};
    sb = new();
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_byte <= 8'h00;
    string_last <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= REG_MODE_ADDR;
    pwdata <= 32'd0;
    burst_left = 6;
    req_count = 0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // url encode from reset: byte extremes, a safe mark, an escaped mark
    offer(8'h00, 1'b0);
    offer(8'hFF, 1'b0);
    offer(CH_TILDE, 1'b0);
    offer(CH_PCT, 1'b1);

    // html encode: every entity and a high byte
    settle();
    set_codec_mode(MODE_HTML_ENC);
    offer(CH_LT, 1'b0);
    offer(CH_GT, 1'b0);
    offer(CH_AMP, 1'b0);
    offer(CH_QUOT, 1'b0);
    offer(CH_APOS, 1'b0);
    offer(8'h80, 1'b1);

    // url decode corner cases
    settle();
    set_codec_mode(MODE_URL_DEC);
    offer(CH_PCT, 1'b0);
    offer("4", 1'b0);
    offer("1", 1'b0);
    offer(CH_PLUS, 1'b0);
    // bad second digit
    offer(CH_PCT, 1'b0);
    offer("4", 1'b0);
    offer("g", 1'b0);
    // bad first digit
    offer(CH_PCT, 1'b0);
    offer("z", 1'b0);
    // escape closing the string
    offer(CH_PCT, 1'b0);
    offer("a", 1'b0);
    offer("F", 1'b1);
    // flush of a lone percent and of percent plus digit
    offer(CH_PCT, 1'b1);
    offer(CH_PCT, 1'b0);
    offer("7", 1'b1);
    // mode write drops a held percent
    offer(CH_PCT, 1'b0);
    settle();
    set_codec_mode(MODE_URL_DEC);
    offer("4", 1'b0);
    offer("1", 1'b1);

    // unused mode passes bytes through
    settle();
    set_codec_mode(MODE_PASS);
    offer(CH_LT, 1'b0);
    offer(8'hFF, 1'b1);

    // random phases across the modes
    foreach (phase_modes[p]) begin
      settle();
      set_codec_mode(phase_modes[p]);
      if (phase_modes[p] == MODE_URL_DEC) run_decode(35);
      else run_encode(22);
    end

    settle();
    if (sb.fail_count == 0 && sb.expected_out.size() == 0) begin
      $display("PASS url_html_escape_codec");
    end else begin
      $display("FAIL url_html_escape_codec");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: url_html_escape_codec.f
rtl/uhe_pkg.sv
rtl/uhe_front.sv
rtl/uhe_queue.sv
rtl/uhe_back.sv
rtl/url_html_escape_codec.sv
sim/tb.sv
